// File: rtl/core/bss_pkg.sv
// Shared types, codes and helpers for the Bernstein specificity scorer.
// Depends on nothing; every other file of the block imports it.
package bss_pkg;

   // Default number of fractional bits of all fixed-point values.
   localparam int unsigned FRACTION_BITS_DEFAULT = 16;

   // Input mode codes.
   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_CELL  = 2'd1;
   localparam logic [1:0] MODE_GENE  = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_INV_MEAN_DENSITY = 1'b0;
   localparam logic CSR_CELL_TOTAL       = 1'b1;

   // Shift applied after a product.
   localparam logic [1:0] SH_FRAC = 2'd0;
   localparam logic [1:0] SH_32   = 2'd1;
   localparam logic [1:0] SH_NONE = 2'd2;

   // Saturation width of a product.
   localparam logic [1:0] CAP_32 = 2'd0;
   localparam logic [1:0] CAP_40 = 2'd1;
   localparam logic [1:0] CAP_48 = 2'd2;
   localparam logic [1:0] CAP_64 = 2'd3;

   // round(2^32 / ln 10), turns a natural-log score into log10.
   localparam logic [63:0] INV_LN10_Q32 = 64'd1865280597;

   // ceil(2^65 / 3); a 64-bit value times this, shifted right 65, is value / 3.
   localparam logic [63:0] RECIP3_Q65 = 64'hAAAA_AAAA_AAAA_AAAB;

   // Work kinds after classification.
   typedef enum logic [1:0] {
      KIND_CLEAR,
      KIND_CELL,
      KIND_GENE
   } kind_type;

   // One queued work item.
   typedef struct packed {
      kind_type    kind;
      logic [31:0] member_weight;
      logic [16:0] cell_density;
      logic [47:0] observed;
      logic [16:0] gene_density;
      logic [31:0] gene_mean;
   } item_type;

   // Saturating 64-bit add.
   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

endpackage

// File: rtl/core/bss_front.sv
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on bss_pkg.
module bss_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [31:0]          req_member_weight,
   input  logic [16:0]          req_cell_density,
   input  logic [47:0]          req_observed,
   input  logic [16:0]          req_gene_density,
   input  logic [31:0]          req_gene_mean,
   output logic                 q_valid,
   output bss_pkg::item_type    q_item,
   input  logic                 q_pop
);
   import bss_pkg::*;

   item_type    entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        push;
   item_type    item_w;

   assign req_ready = (count_ff != 2'd2);
   assign accept    = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   // Classify the beat; the unused mode is dropped here.
   always_comb begin
      item_w.member_weight = req_member_weight;
      item_w.cell_density  = req_cell_density;
      item_w.observed      = req_observed;
      item_w.gene_density  = req_gene_density;
      item_w.gene_mean     = req_gene_mean;
      item_w.kind          = KIND_CLEAR;
      push                 = accept;
      unique case (req_mode)
         MODE_CLEAR: item_w.kind = KIND_CLEAR;
         MODE_CELL:  item_w.kind = KIND_CELL;
         MODE_GENE:  item_w.kind = KIND_GENE;
         default:    push = 1'b0;
      endcase
   end

   // Queue pointers and fill count.
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_w;
      end
   end

endmodule

// File: rtl/core/bss_mul.sv
// Multi-cycle 64x64 multiplier built from one 32x32 multiplier, with a
// selectable right shift and saturation. Depends on bss_pkg.
module bss_mul #(
   parameter int unsigned FRACTION_BITS = bss_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   input  logic [1:0]    shift_sel,
   input  logic [1:0]    cap_sel,
   output logic          done,
   output logic [63:0]   result,
   output logic [127:0]  product
);
   import bss_pkg::*;

   logic          busy_ff;
   logic [2:0]    step_ff;
   logic [63:0]   a_ff, b_ff;
   logic [1:0]    shift_ff, cap_ff;
   logic [63:0]   pp_ff;
   logic [1:0]    pk_ff;
   logic [127:0]  acc_ff;
   logic [63:0]   res_ff;
   logic          done_ff;
   logic [31:0]   x_w, y_w;
   logic [1:0]    pk_w;
   logic [127:0]  pp_sh;
   logic [127:0]  sh_w;
   logic [63:0]   sat_w;

   // Partial product selection for each step.
   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin x_w = a_ff[31:0];  y_w = b_ff[31:0];  pk_w = 2'd0; end
         2'd1: begin x_w = a_ff[31:0];  y_w = b_ff[63:32]; pk_w = 2'd1; end
         2'd2: begin x_w = a_ff[63:32]; y_w = b_ff[31:0];  pk_w = 2'd1; end
         default: begin x_w = a_ff[63:32]; y_w = b_ff[63:32]; pk_w = 2'd2; end
      endcase
   end

   // Place the registered partial product.
   always_comb begin
      case (pk_ff)
         2'd0:    pp_sh = {64'd0, pp_ff};
         2'd1:    pp_sh = {32'd0, pp_ff, 32'd0};
         default: pp_sh = {pp_ff, 64'd0};
      endcase
   end

   // Final shift and saturation.
   always_comb begin
      unique case (shift_ff)
         SH_FRAC: sh_w = acc_ff >> FRACTION_BITS;
         SH_32:   sh_w = acc_ff >> 32;
         default: sh_w = acc_ff;
      endcase
      unique case (cap_ff)
         CAP_32:  sat_w = (|sh_w[127:32]) ? 64'h0000_0000_FFFF_FFFF : sh_w[63:0];
         CAP_40:  sat_w = (|sh_w[127:40]) ? 64'h0000_00FF_FFFF_FFFF : sh_w[63:0];
         CAP_48:  sat_w = (|sh_w[127:48]) ? 64'h0000_FFFF_FFFF_FFFF : sh_w[63:0];
         default: sat_w = (|sh_w[127:64]) ? {64{1'b1}} : sh_w[63:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: one 32x32 product per cycle, added to the accumulator in the cycle after it is registered.
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff     <= a;
         b_ff     <= b;
         shift_ff <= shift_sel;
         cap_ff   <= cap_sel;
         acc_ff   <= '0;
      end else if (busy_ff) begin
         if (step_ff <= 3'd3) begin
            pp_ff <= {32'd0, x_w} * {32'd0, y_w};
            pk_ff <= pk_w;
         end
         if (step_ff >= 3'd1 && step_ff <= 3'd4) begin
            acc_ff <= acc_ff + pp_sh;
         end
         if (step_ff == 3'd5) begin
            res_ff <= sat_w;
         end
      end
   end

   assign done    = done_ff;
   assign result  = res_ff;
   assign product = acc_ff;

endmodule

// File: rtl/core/bss_div.sv
// Restoring divider, one quotient bit per cycle, 128-bit or 64-bit dividend
// by a 64-bit divisor, quotient saturated at 64 bits. Depends on bss_pkg.
module bss_div (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          short_num,
   input  logic [127:0]  num,
   input  logic [63:0]   den,
   output logic          done,
   output logic [63:0]   quotient
);
   import bss_pkg::*;

   logic          busy_ff;
   logic [7:0]    left_ff;
   logic [127:0]  num_ff;
   logic [63:0]   den_ff;
   logic [63:0]   rem_ff;
   logic [63:0]   quo_ff;
   logic          over_ff;
   logic          done_ff;
   logic [64:0]   trial_w;
   logic          take_w;
   logic [63:0]   rem_in;

   // One restoring step.
   always_comb begin
      trial_w = {rem_ff, num_ff[127]};
      take_w  = trial_w[64] || (trial_w[63:0] >= den_ff);
      rem_in  = take_w ? (trial_w[63:0] - den_ff) : trial_w[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         left_ff <= 8'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            left_ff <= short_num ? 8'd64 : 8'd128;
         end else if (busy_ff) begin
            left_ff <= left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // A short dividend has a zero upper half, so its steps are skipped.
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= short_num ? {num[63:0], 64'd0} : num;
         den_ff  <= den;
         rem_ff  <= '0;
         quo_ff  <= '0;
         over_ff <= 1'b0;
      end else if (busy_ff) begin
         num_ff  <= {num_ff[126:0], 1'b0};
         rem_ff  <= rem_in;
         quo_ff  <= {quo_ff[62:0], take_w};
         over_ff <= over_ff | quo_ff[63];
      end
   end

   assign done     = done_ff;
   assign quotient = over_ff ? {64{1'b1}} : quo_ff;

endmodule

// File: rtl/core/bss_back.sv
// Back end: sequences the group statistics and the gene scoring through
// the shared multiplier and divider. Depends on bss_pkg, bss_mul, bss_div.
module bss_back #(
   parameter int unsigned FRACTION_BITS = bss_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  bss_pkg::item_type  q_item,
   output logic               q_pop,
   input  logic [31:0]        inv_mean_density,
   input  logic [24:0]        cell_total,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_mean_profile,
   output logic [39:0]        rsp_upper_score,
   output logic [39:0]        rsp_lower_score
);
   import bss_pkg::*;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_BETA   = 5'd1;
   localparam logic [4:0] S_G      = 5'd2;
   localparam logic [4:0] S_GG     = 5'd3;
   localparam logic [4:0] S_AVG    = 5'd4;
   localparam logic [4:0] S_RPRF   = 5'd5;
   localparam logic [4:0] S_GM2    = 5'd6;
   localparam logic [4:0] S_RPRF2  = 5'd7;
   localparam logic [4:0] S_EXP    = 5'd8;
   localparam logic [4:0] S_NU     = 5'd9;
   localparam logic [4:0] S_DSQ    = 5'd10;
   localparam logic [4:0] S_LDIV   = 5'd11;
   localparam logic [4:0] S_LLOG   = 5'd12;
   localparam logic [4:0] S_PEAK   = 5'd13;
   localparam logic [4:0] S_DA     = 5'd14;
   localparam logic [4:0] S_DIV3   = 5'd15;
   localparam logic [4:0] S_UDIV   = 5'd16;
   localparam logic [4:0] S_ULOG   = 5'd17;
   localparam logic [4:0] S_OUT    = 5'd18;

   logic [4:0]    state_ff;
   logic          wait_ff;
   item_type      item_ff;
   logic [63:0]   t1_ff, t2_ff, nu_ff;
   logic [127:0]  sq_ff;
   logic [63:0]   wsum_ff, wsq_ff;
   logic [47:0]   peak_ff;
   logic [31:0]   avg_ff;
   logic [39:0]   upper_ff, lower_ff;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_avg_ff;
   logic [39:0]   rsp_upper_ff, rsp_lower_ff;

   logic          is_mul, is_div;
   logic          mul_start, div_start;
   logic [63:0]   mul_a, mul_b;
   logic [1:0]    mul_sh, mul_cap;
   logic          div_short;
   logic [127:0]  div_num;
   logic [63:0]   div_den;
   logic          mul_done, div_done;
   logic [63:0]   mul_res, div_q;
   logic [127:0]  mul_prod;
   logic          op_done;
   logic [63:0]   obs_w, d_w, den_w, third_w;
   logic [24:0]   ctot_w;

   assign obs_w   = {16'd0, item_ff.observed};
   assign d_w     = (obs_w > t1_ff) ? (obs_w - t1_ff) : (t1_ff - obs_w);
   assign ctot_w  = (cell_total == 25'd0) ? 25'd1 : cell_total;
   // Reciprocal product of the divide-by-three step, taken from the full product.
   assign third_w = {1'b0, mul_prod[127:65]};
   assign den_w   = add_sat(nu_ff, third_w);

   // Operand selection for the shared units.
   always_comb begin
      is_mul    = 1'b0;
      is_div    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mul_sh    = SH_FRAC;
      mul_cap   = CAP_64;
      div_short = 1'b1;
      div_num   = '0;
      div_den   = 64'd1;
      unique case (state_ff)
         S_BETA: begin
            is_mul  = 1'b1;
            mul_a   = {47'd0, item_ff.cell_density};
            mul_b   = {32'd0, inv_mean_density};
            mul_cap = CAP_32;
         end
         S_G: begin
            is_mul  = 1'b1;
            mul_a   = {32'd0, item_ff.member_weight};
            mul_b   = t1_ff;
            mul_cap = CAP_48;
         end
         S_GG: begin
            is_mul = 1'b1;
            mul_a  = t2_ff;
            mul_b  = t2_ff;
         end
         S_AVG: begin
            is_div  = 1'b1;
            div_num = {64'd0, obs_w};
            div_den = {39'd0, ctot_w};
         end
         S_RPRF: begin
            is_mul = 1'b1;
            mul_a  = {47'd0, item_ff.gene_density};
            mul_b  = {32'd0, item_ff.gene_mean};
         end
         S_GM2: begin
            is_mul = 1'b1;
            mul_a  = {32'd0, item_ff.gene_mean};
            mul_b  = {32'd0, item_ff.gene_mean};
         end
         S_RPRF2: begin
            is_mul = 1'b1;
            mul_a  = {47'd0, item_ff.gene_density};
            mul_b  = t2_ff;
         end
         S_EXP: begin
            is_mul = 1'b1;
            mul_a  = t1_ff;
            mul_b  = wsum_ff;
         end
         S_NU: begin
            is_mul = 1'b1;
            mul_a  = t2_ff;
            mul_b  = wsq_ff;
         end
         S_DSQ: begin
            is_mul = 1'b1;
            mul_a  = d_w;
            mul_b  = d_w;
            mul_sh = SH_NONE;
         end
         S_LDIV: begin
            is_div    = 1'b1;
            div_short = 1'b0;
            div_num   = sq_ff;
            div_den   = nu_ff;
         end
         S_LLOG, S_ULOG: begin
            is_mul  = 1'b1;
            mul_a   = t2_ff;
            mul_b   = INV_LN10_Q32;
            mul_sh  = SH_32;
            mul_cap = CAP_40;
         end
         S_PEAK: begin
            is_mul = 1'b1;
            mul_a  = {32'd0, item_ff.gene_mean};
            mul_b  = {16'd0, peak_ff};
         end
         S_DA: begin
            is_mul = 1'b1;
            mul_a  = d_w;
            mul_b  = t2_ff;
         end
         S_DIV3: begin
            is_mul = 1'b1;
            mul_a  = t2_ff;
            mul_b  = RECIP3_Q65;
            mul_sh = SH_NONE;
         end
         S_UDIV: begin
            is_div    = 1'b1;
            div_short = 1'b0;
            div_num   = sq_ff;
            div_den   = t2_ff;
         end
         default: ;
      endcase
   end

   assign mul_start = is_mul && !wait_ff;
   assign div_start = is_div && !wait_ff;
   assign op_done   = wait_ff && (mul_done || div_done);
   assign q_pop     = (state_ff == S_IDLE) && q_valid;

   bss_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
      .clock     (clock),
      .reset     (reset),
      .start     (mul_start),
      .a         (mul_a),
      .b         (mul_b),
      .shift_sel (mul_sh),
      .cap_sel   (mul_cap),
      .done      (mul_done),
      .result    (mul_res),
      .product   (mul_prod)
   );

   bss_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .short_num (div_short),
      .num       (div_num),
      .den       (div_den),
      .done      (div_done),
      .quotient  (div_q)
   );

   // Sequencer and statistics.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wsum_ff      <= '0;
         wsq_ff       <= '0;
         peak_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_start || div_start) begin
            wait_ff <= 1'b1;
         end else if (op_done) begin
            wait_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  unique case (q_item.kind)
                     KIND_CLEAR: begin
                        wsum_ff <= '0;
                        wsq_ff  <= '0;
                        peak_ff <= '0;
                     end
                     KIND_CELL: state_ff <= S_BETA;
                     default:   state_ff <= S_AVG;
                  endcase
               end
            end
            S_BETA:  if (op_done) state_ff <= S_G;
            S_G:     if (op_done) state_ff <= S_GG;
            S_GG: begin
               if (op_done) begin
                  wsum_ff <= add_sat(wsum_ff, t2_ff);
                  wsq_ff  <= add_sat(wsq_ff, mul_res);
                  if (t2_ff[47:0] > peak_ff) peak_ff <= t2_ff[47:0];
                  state_ff <= S_IDLE;
               end
            end
            S_AVG:   if (op_done) state_ff <= S_RPRF;
            S_RPRF:  if (op_done) state_ff <= S_GM2;
            S_GM2:   if (op_done) state_ff <= S_RPRF2;
            S_RPRF2: if (op_done) state_ff <= S_EXP;
            S_EXP:   if (op_done) state_ff <= S_NU;
            S_NU:    if (op_done) state_ff <= S_DSQ;
            S_DSQ: begin
               if (op_done) begin
                  if (obs_w < t1_ff) begin
                     state_ff <= (nu_ff != 64'd0) ? S_LDIV : S_OUT;
                  end else if (obs_w > t1_ff) begin
                     state_ff <= S_PEAK;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_LDIV:  if (op_done) state_ff <= S_LLOG;
            S_LLOG:  if (op_done) state_ff <= S_OUT;
            S_PEAK:  if (op_done) state_ff <= S_DA;
            S_DA:    if (op_done) state_ff <= S_DIV3;
            S_DIV3:  if (op_done) state_ff <= (den_w != 64'd0) ? S_UDIV : S_OUT;
            S_UDIV:  if (op_done) state_ff <= S_ULOG;
            S_ULOG:  if (op_done) state_ff <= S_OUT;
            S_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff  <= q_item;
         upper_ff <= '0;
         lower_ff <= '0;
      end
      if (op_done) begin
         unique case (state_ff)
            S_BETA, S_RPRF, S_EXP:               t1_ff <= mul_res;
            S_G, S_GM2, S_RPRF2, S_PEAK, S_DA:   t2_ff <= mul_res;
            S_LDIV, S_UDIV:                      t2_ff <= div_q;
            S_DIV3:                              t2_ff <= den_w;
            S_NU:                                nu_ff <= mul_res;
            S_DSQ:                               sq_ff <= {1'b0, mul_prod[127:1]};
            S_AVG:    avg_ff   <= (|div_q[63:32]) ? 32'hFFFF_FFFF : div_q[31:0];
            S_LLOG:   lower_ff <= mul_res[39:0];
            S_ULOG:   upper_ff <= mul_res[39:0];
            default: ;
         endcase
      end
      if (state_ff == S_OUT && !rsp_valid_ff) begin
         rsp_avg_ff   <= avg_ff;
         rsp_upper_ff <= upper_ff;
         rsp_lower_ff <= lower_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mean_profile = rsp_avg_ff;
   assign rsp_upper_score  = rsp_upper_ff;
   assign rsp_lower_score  = rsp_lower_ff;

   // The peak weight never exceeds the saturating weight sum.
   a_peak_le_sum: assert property (@(posedge clock) disable iff (reset)
      {16'd0, peak_ff} <= wsum_ff)
      else $error("weight peak above weight sum");

   // A result beat is only raised from the output state.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   // The two shared units are never started together.
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_start && div_start))
      else $error("multiplier and divider started together");

endmodule

// File: rtl/core/bernstein_specificity_scorer.sv
// Bernstein specificity scorer. A clear beat is handled in the back end's
// idle state, a cell beat takes three passes of the 4-partial 64x64
// multiplier, and a gene beat takes the average profile divide, six to
// ten products and at most one tail divide, the divide by three being
// one of the products as a reciprocal product. The shared divider makes
// one quotient bit per cycle. A two-entry queue keeps the input side open,
// until it fills, while the back end works or a result waits.
module bernstein_specificity_scorer #(
   parameter int unsigned FRACTION_BITS = bss_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_mode,
   input  logic [31:0]   req_member_weight,
   input  logic [16:0]   req_cell_density,
   input  logic [47:0]   req_observed,
   input  logic [16:0]   req_gene_density,
   input  logic [31:0]   req_gene_mean,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic [31:0]   rsp_mean_profile,
   output logic [39:0]   rsp_upper_score,
   output logic [39:0]   rsp_lower_score,
   input  logic          csr_we,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata
);
   import bss_pkg::*;

   logic [31:0]  inv_mean_density_ff;
   logic [24:0]  cell_total_ff;
   logic         q_valid;
   item_type     q_item;
   logic         q_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mean_density_ff <= 32'(1) << FRACTION_BITS;
         cell_total_ff       <= 25'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INV_MEAN_DENSITY: inv_mean_density_ff <= csr_wdata;
            default:              cell_total_ff       <= csr_wdata[24:0];
         endcase
      end
   end

   bss_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_member_weight (req_member_weight),
      .req_cell_density  (req_cell_density),
      .req_observed      (req_observed),
      .req_gene_density  (req_gene_density),
      .req_gene_mean     (req_gene_mean),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   bss_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .inv_mean_density    (inv_mean_density_ff),
      .cell_total          (cell_total_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_mean_profile    (rsp_mean_profile),
      .rsp_upper_score     (rsp_upper_score),
      .rsp_lower_score     (rsp_lower_score)
   );

endmodule
